// ----- src/dsa_pkg.sv -----
`timescale 1ns / 1ps
// dsa_pkg: shared types and constants of the descriptor slot allocator.
// No dependencies.
package dsa_pkg;

  localparam int SHADER_CAP = 1024;
  localparam int TARGET_CAP = 64;
  localparam int DEPTH_CAP  = 64;
  localparam int SHADER_STRIDE = 32;
  localparam int TARGET_STRIDE = 32;
  localparam int DEPTH_STRIDE  = 32;

  // top-of-stack counters hold 0..capacity
  localparam int SHD_TW = $clog2(SHADER_CAP + 1);
  localparam int TGT_TW = $clog2(TARGET_CAP + 1);
  localparam int DEP_TW = $clog2(DEPTH_CAP + 1);
  localparam int TOP_W  = (SHD_TW > TGT_TW) ? ((SHD_TW > DEP_TW) ? SHD_TW : DEP_TW)
                                            : ((TGT_TW > DEP_TW) ? TGT_TW : DEP_TW);
  // stack addresses
  localparam int SHD_AW = (SHADER_CAP > 1) ? $clog2(SHADER_CAP) : 1;
  localparam int TGT_AW = (TARGET_CAP > 1) ? $clog2(TARGET_CAP) : 1;
  localparam int DEP_AW = (DEPTH_CAP > 1) ? $clog2(DEPTH_CAP) : 1;
  localparam int POS_W  = (SHD_AW > TGT_AW) ? ((SHD_AW > DEP_AW) ? SHD_AW : DEP_AW)
                                            : ((TGT_AW > DEP_AW) ? TGT_AW : DEP_AW);

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ADDR_W  = 64;
  localparam int SHD_SZW = 11;
  localparam int TGT_SZW = 7;
  localparam int DEP_SZW = 7;
  localparam int STR_W   = 9;
  localparam int OFF_W   = IDX_W + STR_W;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 64;
  localparam int KIND_W  = 2;
  localparam int POOL_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;

  localparam logic [POOL_W-1:0] POOL_SHD = 2'd0;
  localparam logic [POOL_W-1:0] POOL_TGT = 2'd1;
  localparam logic [POOL_W-1:0] POOL_DEP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_HDL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

  localparam logic [CFG_IW-1:0] REG_SHD_SIZE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TGT_SIZE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DEP_SIZE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SHD_CPU  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SHD_GPU  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TGT_CPU  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_DEP_CPU  = 3'd6;

  typedef struct packed {
    logic load;  // capture the request
    logic exec;  // stack pop/push, memory read issued
    logic emit;  // form addresses into the output register
  } dsa_cmd_t;

  typedef struct packed {
    logic out_room;
  } dsa_stat_t;

endpackage

// ----- src/dsa_ctrl.sv -----
`timescale 1ns / 1ps
// dsa_ctrl: request sequencer of the descriptor slot allocator.
// Depends on dsa_pkg.
module dsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  dsa_pkg::dsa_stat_t stat_i,
  output dsa_pkg::dsa_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_CALC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_CALC;
      end
      ST_CALC: begin
        if (stat_i.out_room) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/dsa_datapath.sv -----
`timescale 1ns / 1ps
// dsa_datapath: free-list stacks, counters, config registers and output register.
// Depends on dsa_pkg.
module dsa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dsa_pkg::dsa_cmd_t             cmd_i,
  output dsa_pkg::dsa_stat_t            stat_o,
  input  logic [dsa_pkg::KIND_W-1:0]    kind_i,
  input  logic [dsa_pkg::POOL_W-1:0]    pool_i,
  input  logic [dsa_pkg::IDX_W-1:0]     slot_i,
  input  logic                          hvalid_i,
  input  logic                          cfg_we_i,
  input  logic [dsa_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [dsa_pkg::CFG_DW-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dsa_pkg::STAT_W-1:0]    out_status_o,
  output logic [dsa_pkg::IDX_W-1:0]     out_idx_o,
  output logic [dsa_pkg::ADDR_W-1:0]    out_cpu_o,
  output logic [dsa_pkg::ADDR_W-1:0]    out_gpu_o,
  output logic [dsa_pkg::CNT_W-1:0]     out_free_o,
  output logic [dsa_pkg::CNT_W-1:0]     out_used_o
);

  localparam int TW = dsa_pkg::TOP_W;

  // config registers
  logic [dsa_pkg::SHD_SZW-1:0] shd_size_q;
  logic [dsa_pkg::TGT_SZW-1:0] tgt_size_q;
  logic [dsa_pkg::DEP_SZW-1:0] dep_size_q;
  logic [dsa_pkg::ADDR_W-1:0]  shd_cpu_q, shd_gpu_q, tgt_cpu_q, dep_cpu_q;

  // stack pointers; lw = low-water mark, entries below it still hold their own index
  logic [dsa_pkg::SHD_TW-1:0] shd_top_q, shd_lw_q, shd_clip, shd_new_clip;
  logic [dsa_pkg::TGT_TW-1:0] tgt_top_q, tgt_lw_q, tgt_clip, tgt_new_clip;
  logic [dsa_pkg::DEP_TW-1:0] dep_top_q, dep_lw_q, dep_clip, dep_new_clip;

  // request
  logic [dsa_pkg::KIND_W-1:0] kind_q;
  logic [dsa_pkg::POOL_W-1:0] pool_q;
  logic [dsa_pkg::IDX_W-1:0]  slot_q;
  logic                       hv_q;

  // stage after stack access
  logic [dsa_pkg::STAT_W-1:0] st_status_q;
  logic                       st_pop_q, st_hit_q;
  logic [dsa_pkg::POS_W-1:0]  st_pos_q;
  logic [dsa_pkg::POOL_W-1:0] st_pool_q;
  logic [dsa_pkg::CNT_W-1:0]  st_free_q, st_used_q;

  // memories
  logic [dsa_pkg::IDX_W-1:0]  shd_mem [dsa_pkg::SHADER_CAP];
  logic [dsa_pkg::TGT_AW-1:0] tgt_mem [dsa_pkg::TARGET_CAP];
  logic [dsa_pkg::DEP_AW-1:0] dep_mem [dsa_pkg::DEPTH_CAP];
  logic [dsa_pkg::IDX_W-1:0]  shd_rd_q;
  logic [dsa_pkg::TGT_AW-1:0] tgt_rd_q;
  logic [dsa_pkg::DEP_AW-1:0] dep_rd_q;

  always_comb begin
    shd_clip = (32'(shd_size_q) < 32'(dsa_pkg::SHADER_CAP)) ?
               dsa_pkg::SHD_TW'(shd_size_q) : dsa_pkg::SHD_TW'(dsa_pkg::SHADER_CAP);
    tgt_clip = (32'(tgt_size_q) < 32'(dsa_pkg::TARGET_CAP)) ?
               dsa_pkg::TGT_TW'(tgt_size_q) : dsa_pkg::TGT_TW'(dsa_pkg::TARGET_CAP);
    dep_clip = (32'(dep_size_q) < 32'(dsa_pkg::DEPTH_CAP)) ?
               dsa_pkg::DEP_TW'(dep_size_q) : dsa_pkg::DEP_TW'(dsa_pkg::DEPTH_CAP);
    shd_new_clip = (32'(cfg_data_i[dsa_pkg::SHD_SZW-1:0]) < 32'(dsa_pkg::SHADER_CAP)) ?
                   dsa_pkg::SHD_TW'(cfg_data_i[dsa_pkg::SHD_SZW-1:0]) :
                   dsa_pkg::SHD_TW'(dsa_pkg::SHADER_CAP);
    tgt_new_clip = (32'(cfg_data_i[dsa_pkg::TGT_SZW-1:0]) < 32'(dsa_pkg::TARGET_CAP)) ?
                   dsa_pkg::TGT_TW'(cfg_data_i[dsa_pkg::TGT_SZW-1:0]) :
                   dsa_pkg::TGT_TW'(dsa_pkg::TARGET_CAP);
    dep_new_clip = (32'(cfg_data_i[dsa_pkg::DEP_SZW-1:0]) < 32'(dsa_pkg::DEPTH_CAP)) ?
                   dsa_pkg::DEP_TW'(cfg_data_i[dsa_pkg::DEP_SZW-1:0]) :
                   dsa_pkg::DEP_TW'(dsa_pkg::DEPTH_CAP);
  end

  // selected pool view
  logic          pool_ok;
  logic [TW-1:0] sel_top, sel_lw, sel_size, new_top, pop_pos;
  logic          do_pop, do_push;
  logic [dsa_pkg::STAT_W-1:0] status_c;

  always_comb begin
    pool_ok  = 1'b1;
    sel_top  = '0;
    sel_lw   = '0;
    sel_size = '0;
    unique case (pool_q)
      dsa_pkg::POOL_SHD: begin
        sel_top = TW'(shd_top_q); sel_lw = TW'(shd_lw_q); sel_size = TW'(shd_clip);
      end
      dsa_pkg::POOL_TGT: begin
        sel_top = TW'(tgt_top_q); sel_lw = TW'(tgt_lw_q); sel_size = TW'(tgt_clip);
      end
      dsa_pkg::POOL_DEP: begin
        sel_top = TW'(dep_top_q); sel_lw = TW'(dep_lw_q); sel_size = TW'(dep_clip);
      end
      default: pool_ok = 1'b0;
    endcase

    pop_pos  = sel_top - TW'(1);
    do_pop   = 1'b0;
    do_push  = 1'b0;
    status_c = dsa_pkg::STAT_OK;
    if (pool_ok) begin
      case (kind_q)
        dsa_pkg::KIND_ALLOC: begin
          if (sel_top == '0) status_c = dsa_pkg::STAT_FULL;
          else               do_pop   = cmd_i.exec;
        end
        dsa_pkg::KIND_FREE: begin
          if (!hv_q || (32'(slot_q) >= 32'(sel_size))) status_c = dsa_pkg::STAT_BAD_HDL;
          else if (sel_top >= sel_size)                status_c = dsa_pkg::STAT_OVERFLOW;
          else                                         do_push  = cmd_i.exec;
        end
        default: ;
      endcase
    end
    new_top = do_pop ? pop_pos : (do_push ? sel_top + TW'(1) : sel_top);
  end

  // memories: write on push, registered read at the pop position, held until emit
  logic shd_we, tgt_we, dep_we;
  assign shd_we = do_push && (pool_q == dsa_pkg::POOL_SHD);
  assign tgt_we = do_push && (pool_q == dsa_pkg::POOL_TGT);
  assign dep_we = do_push && (pool_q == dsa_pkg::POOL_DEP);

  always_ff @(posedge clk_i) begin
    if (shd_we) shd_mem[dsa_pkg::SHD_AW'(sel_top)] <= slot_q;
    if (cmd_i.exec) shd_rd_q <= shd_mem[dsa_pkg::SHD_AW'(pop_pos)];
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[dsa_pkg::TGT_AW'(sel_top)] <= dsa_pkg::TGT_AW'(slot_q);
    if (cmd_i.exec) tgt_rd_q <= tgt_mem[dsa_pkg::TGT_AW'(pop_pos)];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dsa_pkg::DEP_AW'(sel_top)] <= dsa_pkg::DEP_AW'(slot_q);
    if (cmd_i.exec) dep_rd_q <= dep_mem[dsa_pkg::DEP_AW'(pop_pos)];
  end

  // config and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shd_size_q <= dsa_pkg::SHD_SZW'(dsa_pkg::SHADER_CAP);
      tgt_size_q <= dsa_pkg::TGT_SZW'(dsa_pkg::TARGET_CAP);
      dep_size_q <= dsa_pkg::DEP_SZW'(dsa_pkg::DEPTH_CAP);
      shd_cpu_q  <= '0;
      shd_gpu_q  <= '0;
      tgt_cpu_q  <= '0;
      dep_cpu_q  <= '0;
      shd_top_q  <= dsa_pkg::SHD_TW'(dsa_pkg::SHADER_CAP);
      shd_lw_q   <= dsa_pkg::SHD_TW'(dsa_pkg::SHADER_CAP);
      tgt_top_q  <= dsa_pkg::TGT_TW'(dsa_pkg::TARGET_CAP);
      tgt_lw_q   <= dsa_pkg::TGT_TW'(dsa_pkg::TARGET_CAP);
      dep_top_q  <= dsa_pkg::DEP_TW'(dsa_pkg::DEPTH_CAP);
      dep_lw_q   <= dsa_pkg::DEP_TW'(dsa_pkg::DEPTH_CAP);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsa_pkg::REG_SHD_SIZE: begin
          shd_size_q <= cfg_data_i[dsa_pkg::SHD_SZW-1:0];
          shd_top_q  <= shd_new_clip;
          shd_lw_q   <= shd_new_clip;
        end
        dsa_pkg::REG_TGT_SIZE: begin
          tgt_size_q <= cfg_data_i[dsa_pkg::TGT_SZW-1:0];
          tgt_top_q  <= tgt_new_clip;
          tgt_lw_q   <= tgt_new_clip;
        end
        dsa_pkg::REG_DEP_SIZE: begin
          dep_size_q <= cfg_data_i[dsa_pkg::DEP_SZW-1:0];
          dep_top_q  <= dep_new_clip;
          dep_lw_q   <= dep_new_clip;
        end
        dsa_pkg::REG_SHD_CPU: shd_cpu_q <= cfg_data_i;
        dsa_pkg::REG_SHD_GPU: shd_gpu_q <= cfg_data_i;
        dsa_pkg::REG_TGT_CPU: tgt_cpu_q <= cfg_data_i;
        dsa_pkg::REG_DEP_CPU: dep_cpu_q <= cfg_data_i;
        default: ;
      endcase
    end else if (do_pop || do_push) begin
      unique case (pool_q)
        dsa_pkg::POOL_SHD: begin
          shd_top_q <= dsa_pkg::SHD_TW'(new_top);
          if (do_pop && (dsa_pkg::SHD_TW'(new_top) < shd_lw_q))
            shd_lw_q <= dsa_pkg::SHD_TW'(new_top);
        end
        dsa_pkg::POOL_TGT: begin
          tgt_top_q <= dsa_pkg::TGT_TW'(new_top);
          if (do_pop && (dsa_pkg::TGT_TW'(new_top) < tgt_lw_q))
            tgt_lw_q <= dsa_pkg::TGT_TW'(new_top);
        end
        dsa_pkg::POOL_DEP: begin
          dep_top_q <= dsa_pkg::DEP_TW'(new_top);
          if (do_pop && (dsa_pkg::DEP_TW'(new_top) < dep_lw_q))
            dep_lw_q <= dsa_pkg::DEP_TW'(new_top);
        end
        default: ;
      endcase
    end
  end

  // request and stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      pool_q <= pool_i;
      slot_q <= slot_i;
      hv_q   <= hvalid_i;
    end
    if (cmd_i.exec) begin
      st_status_q <= pool_ok ? status_c : dsa_pkg::STAT_OK;
      st_pop_q    <= do_pop;
      st_hit_q    <= pop_pos < sel_lw;
      st_pos_q    <= dsa_pkg::POS_W'(pop_pos);
      st_pool_q   <= pool_q;
      st_free_q   <= pool_ok ? dsa_pkg::CNT_W'(new_top) : '0;
      st_used_q   <= pool_ok ? dsa_pkg::CNT_W'(sel_size - new_top) : '0;
    end
  end

  // address forming
  logic [dsa_pkg::IDX_W-1:0]  mem_idx, idx_c;
  logic [dsa_pkg::STR_W-1:0]  stride_c;
  logic [dsa_pkg::ADDR_W-1:0] base_c;
  logic [dsa_pkg::OFF_W-1:0]  off_c;

  always_comb begin
    case (st_pool_q)
      dsa_pkg::POOL_SHD: begin
        mem_idx  = shd_rd_q;
        stride_c = dsa_pkg::STR_W'(dsa_pkg::SHADER_STRIDE);
        base_c   = shd_cpu_q;
      end
      dsa_pkg::POOL_TGT: begin
        mem_idx  = dsa_pkg::IDX_W'(tgt_rd_q);
        stride_c = dsa_pkg::STR_W'(dsa_pkg::TARGET_STRIDE);
        base_c   = tgt_cpu_q;
      end
      default: begin
        mem_idx  = dsa_pkg::IDX_W'(dep_rd_q);
        stride_c = dsa_pkg::STR_W'(dsa_pkg::DEPTH_STRIDE);
        base_c   = dep_cpu_q;
      end
    endcase
    if (!st_pop_q)     idx_c = '0;
    else if (st_hit_q) idx_c = dsa_pkg::IDX_W'(st_pos_q);
    else               idx_c = mem_idx;
    off_c = dsa_pkg::OFF_W'(idx_c) * dsa_pkg::OFF_W'(stride_c);
  end

  assign stat_o.out_room = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_o <= st_status_q;
      out_idx_o    <= idx_c;
      out_cpu_o    <= st_pop_q ? base_c + dsa_pkg::ADDR_W'(off_c) : '0;
      out_gpu_o    <= (st_pop_q && (st_pool_q == dsa_pkg::POOL_SHD)) ?
                      shd_gpu_q + dsa_pkg::ADDR_W'(off_c) : '0;
      out_free_o   <= st_free_q;
      out_used_o   <= st_used_q;
    end
  end

endmodule

// ----- src/descriptor_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
// descriptor_slot_allocator_unit: top level of the three-pool LIFO slot allocator.
// Depends on dsa_pkg, dsa_ctrl, dsa_datapath.
//
//  channel   dir   handshake                    payload
//  s_axis    in    s_axis_tvalid/s_axis_tready  tuser kind,pool,handle_valid; tdata slot
//  m_axis    out   m_axis_tvalid/m_axis_tready  tuser status; tdata index,addresses,counts
//  cfg       in    cfg_we_i                     cfg_idx_i, cfg_data_i
//
// Each request steps in turn through capture, stack access with registered memory
// read, address forming into the output register. The next request is taken
// while a result waits in the output register; a stalled output holds the
// sequencer in its last step. No clearing pass after reset: a low-water mark
// per pool marks stack entries that still hold their own index.
module descriptor_slot_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [9:0] slot_to_free
  input  logic [4:0]   s_axis_tuser,   // [1:0] kind, [3:2] pool, [4] handle_valid
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // slot_index, cpu_address, gpu_address,
                                       // free_count, used_count
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  dsa_pkg::dsa_cmd_t  cmd;
  dsa_pkg::dsa_stat_t stat;

  logic [dsa_pkg::IDX_W-1:0]  out_idx;
  logic [dsa_pkg::ADDR_W-1:0] out_cpu, out_gpu;
  logic [dsa_pkg::CNT_W-1:0]  out_free, out_used;

  dsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (s_axis_tuser[1:0]),
    .pool_i       (s_axis_tuser[3:2]),
    .slot_i       (s_axis_tdata[9:0]),
    .hvalid_i     (s_axis_tuser[4]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_idx_o    (out_idx),
    .out_cpu_o    (out_cpu),
    .out_gpu_o    (out_gpu),
    .out_free_o   (out_free),
    .out_used_o   (out_used)
  );

  assign m_axis_tdata = {out_used, out_free, out_gpu, out_cpu, out_idx};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dsa_pkg::STAT_FULL) |->
      (out_idx == '0) && (out_cpu == '0) && (out_gpu == '0))
    else $error("failed allocation carries a slot");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (13'(out_free) + 13'(out_used)) <= 13'(dsa_pkg::SHADER_CAP))
    else $error("free plus used exceeds pool size");

endmodule
